// ===== hw/rtl/lco_pkg.sv =====
// Shared types and constants for the line clipper.
`default_nettype none

package lco_pkg;

	// Region outcode bits.
	localparam logic [3:0] OC_LEFT   = 4'd1;
	localparam logic [3:0] OC_RIGHT  = 4'd2;
	localparam logic [3:0] OC_BOTTOM = 4'd4;
	localparam logic [3:0] OC_TOP    = 4'd8;

	// Configuration register indexes.
	localparam int CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] REG_LEFT   = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT  = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_BOTTOM = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_TOP    = 2'd3;

	// Reset values of the clip rectangle.
	localparam int RST_LEFT   = 0;
	localparam int RST_RIGHT  = 1023;
	localparam int RST_BOTTOM = 0;
	localparam int RST_TOP    = 767;

	// Upper bound on edge clips per segment.
	localparam int PASS_BITS = 4;
	localparam logic [PASS_BITS-1:0] CLIP_PASSES = 4'd8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CODE,
		ST_DECIDE,
		ST_MUL,
		ST_DIV,
		ST_UPD,
		ST_DONE
	} lco_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/line_clip_outcode.sv =====
// Line clipper: outcode test and edge intersection with an iterative divider.
// A segment that needs no clip passes an outcode test and a decision between its input
// and result beats. Each edge clip adds one multiply, COORD_BITS + 1 divide steps of
// the shared restoring divider unless the divisor is zero, an endpoint update and a new
// outcode test. One segment at a time; the next input beat is taken in the cycle after
// the result beat. arst_n clears the sequencer and loads the default clip rectangle.
`default_nettype none

module line_clip_outcode #(
	parameter int COORD_BITS = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_we,
	input  wire logic [lco_pkg::CFG_IDX_BITS-1:0]       cfg_index,
	input  wire logic signed [COORD_BITS-1:0]           cfg_data,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic signed [COORD_BITS-1:0]           start_x,
	input  wire logic signed [COORD_BITS-1:0]           start_y,
	input  wire logic signed [COORD_BITS-1:0]           end_x,
	input  wire logic signed [COORD_BITS-1:0]           end_y,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic                                        accepted,
	output logic signed [COORD_BITS-1:0]                clipped_start_x,
	output logic signed [COORD_BITS-1:0]                clipped_start_y,
	output logic signed [COORD_BITS-1:0]                clipped_end_x,
	output logic signed [COORD_BITS-1:0]                clipped_end_y
);

	import lco_pkg::*;

	localparam int W = COORD_BITS;
	// Differences and magnitudes need one more bit than a coordinate.
	localparam int DW = W + 1;
	localparam int PW = 2 * DW;
	localparam int STEP_BITS = $clog2(DW);
	localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(DW - 1);

	lco_state_t state_q, state_d;

	logic signed [W-1:0] left_q, right_q, bottom_q, top_q;
	logic signed [W-1:0] x0_q, y0_q, x1_q, y1_q;
	logic [3:0] c0_q, c1_q;
	logic [PASS_BITS-1:0] pass_q;
	logic acc_q;

	logic signed [W-1:0] p_q, fix_q;
	logic [DW-1:0] mag_d_q, mag_num_q, mag_den_q;
	logic neg_q, move_x_q, sel_end_q, den_zero_q;
	logic [DW-1:0] rem_q, dq_q;
	logic [STEP_BITS-1:0] step_q;

	logic rect_ok;
	logic [3:0] c0_new, c1_new, sel;
	logic sel_end;
	logic signed [DW-1:0] dx, dy, d_top, d_bot, d_right, d_left;
	logic signed [DW-1:0] op_d, op_num, op_den;
	logic signed [W-1:0] op_p, op_fix;
	logic op_move_x;
	logic [PW-1:0] prod;
	logic [DW:0] r2, r2_diff;
	logic div_ge;
	logic signed [DW:0] upd_sum, upd_q;
	logic signed [W-1:0] new_coord;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= W'(RST_LEFT);
			right_q  <= W'(RST_RIGHT);
			bottom_q <= W'(RST_BOTTOM);
			top_q    <= W'(RST_TOP);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LEFT:   left_q   <= cfg_data;
				REG_RIGHT:  right_q  <= cfg_data;
				REG_BOTTOM: bottom_q <= cfg_data;
				REG_TOP:    top_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign rect_ok = (left_q <= right_q) && (bottom_q <= top_q);

	always_comb begin
		c0_new = '0;
		if (x0_q < left_q) c0_new = c0_new | OC_LEFT;
		else if (x0_q > right_q) c0_new = c0_new | OC_RIGHT;
		if (y0_q < bottom_q) c0_new = c0_new | OC_BOTTOM;
		else if (y0_q > top_q) c0_new = c0_new | OC_TOP;
		c1_new = '0;
		if (x1_q < left_q) c1_new = c1_new | OC_LEFT;
		else if (x1_q > right_q) c1_new = c1_new | OC_RIGHT;
		if (y1_q < bottom_q) c1_new = c1_new | OC_BOTTOM;
		else if (y1_q > top_q) c1_new = c1_new | OC_TOP;
	end

	// Edge selection and intersection operands. The endpoint with the larger
	// code moves; ties go to the first endpoint.
	always_comb begin
		sel_end = (c1_q > c0_q);
		sel     = sel_end ? c1_q : c0_q;
		dx      = $signed({x1_q[W-1], x1_q}) - $signed({x0_q[W-1], x0_q});
		dy      = $signed({y1_q[W-1], y1_q}) - $signed({y0_q[W-1], y0_q});
		d_top   = $signed({top_q[W-1], top_q}) - $signed({y0_q[W-1], y0_q});
		d_bot   = $signed({bottom_q[W-1], bottom_q}) - $signed({y0_q[W-1], y0_q});
		d_right = $signed({right_q[W-1], right_q}) - $signed({x0_q[W-1], x0_q});
		d_left  = $signed({left_q[W-1], left_q}) - $signed({x0_q[W-1], x0_q});
		if ((sel & OC_TOP) != '0) begin
			op_p = x0_q; op_d = dx; op_num = d_top; op_den = dy;
			op_fix = top_q; op_move_x = 1'b1;
		end else if ((sel & OC_BOTTOM) != '0) begin
			op_p = x0_q; op_d = dx; op_num = d_bot; op_den = dy;
			op_fix = bottom_q; op_move_x = 1'b1;
		end else if ((sel & OC_RIGHT) != '0) begin
			op_p = y0_q; op_d = dy; op_num = d_right; op_den = dx;
			op_fix = right_q; op_move_x = 1'b0;
		end else begin
			op_p = y0_q; op_d = dy; op_num = d_left; op_den = dx;
			op_fix = left_q; op_move_x = 1'b0;
		end
	end

	assign prod = PW'(mag_d_q) * PW'(mag_num_q);

	// One restoring divide step: shift in the next dividend bit and subtract.
	assign r2      = {rem_q, dq_q[DW-1]};
	assign r2_diff = r2 - {1'b0, mag_den_q};
	assign div_ge  = !r2_diff[DW];

	assign upd_q     = neg_q ? -$signed({1'b0, dq_q}) : $signed({1'b0, dq_q});
	assign upd_sum   = $signed({{2{p_q[W-1]}}, p_q}) + upd_q;
	assign new_coord = upd_sum[W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = rect_ok ? ST_CODE : ST_DONE;
				end
			end
			ST_CODE: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (pass_q == CLIP_PASSES || (c0_q | c1_q) == '0 || (c0_q & c1_q) != '0) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = den_zero_q ? ST_UPD : ST_DIV;
			end
			ST_DIV: begin
				if (step_q == LAST_STEP) state_d = ST_UPD;
			end
			ST_UPD: begin
				state_d = ST_CODE;
			end
			ST_DONE: begin
				out_valid = 1'b1;
				if (out_ready) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers of the datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c0_q   <= '0;
			c1_q   <= '0;
			pass_q <= '0;
			acc_q  <= 1'b0;
			step_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						pass_q <= '0;
						acc_q  <= 1'b0;
						c0_q   <= '0;
						c1_q   <= '0;
					end
				end
				ST_CODE: begin
					c0_q <= c0_new;
					c1_q <= c1_new;
				end
				ST_DECIDE: begin
					acc_q <= (pass_q != CLIP_PASSES) && ((c0_q | c1_q) == '0);
				end
				ST_MUL: begin
					step_q <= '0;
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
				end
				ST_UPD: begin
					pass_q <= pass_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Coordinate and arithmetic registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					x0_q <= start_x;
					y0_q <= start_y;
					x1_q <= end_x;
					y1_q <= end_y;
				end
			end
			ST_DECIDE: begin
				p_q        <= op_p;
				fix_q      <= op_fix;
				move_x_q   <= op_move_x;
				sel_end_q  <= sel_end;
				mag_d_q    <= op_d[DW-1] ? DW'(-op_d) : DW'(op_d);
				mag_num_q  <= op_num[DW-1] ? DW'(-op_num) : DW'(op_num);
				mag_den_q  <= op_den[DW-1] ? DW'(-op_den) : DW'(op_den);
				neg_q      <= op_d[DW-1] ^ op_num[DW-1] ^ op_den[DW-1];
				den_zero_q <= (op_den == '0);
			end
			ST_MUL: begin
				// The quotient is at most the span of the moving axis, so the
				// upper half of the product is already below the divisor.
				if (den_zero_q) begin
					rem_q <= '0;
					dq_q  <= '0;
				end else begin
					rem_q <= prod[PW-1:DW];
					dq_q  <= prod[DW-1:0];
				end
			end
			ST_DIV: begin
				rem_q <= div_ge ? r2_diff[DW-1:0] : r2[DW-1:0];
				dq_q  <= {dq_q[DW-2:0], div_ge};
			end
			ST_UPD: begin
				if (!sel_end_q) begin
					x0_q <= move_x_q ? new_coord : fix_q;
					y0_q <= move_x_q ? fix_q : new_coord;
				end else begin
					x1_q <= move_x_q ? new_coord : fix_q;
					y1_q <= move_x_q ? fix_q : new_coord;
				end
			end
			default: ;
		endcase
	end

	assign accepted        = acc_q;
	assign clipped_start_x = acc_q ? x0_q : '0;
	assign clipped_start_y = acc_q ? y0_q : '0;
	assign clipped_end_x   = acc_q ? x1_q : '0;
	assign clipped_end_y   = acc_q ? y1_q : '0;

	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("input and output handshakes open at once");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> !den_zero_q && mag_den_q != '0)
		else $error("divider running with a zero divisor");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPD && !den_zero_q |-> rem_q < mag_den_q)
		else $error("divide remainder not below divisor");

	a_pass_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pass_q <= CLIP_PASSES)
		else $error("clip pass count beyond its bound");

	a_acc_inside: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |-> c0_q == '0 && c1_q == '0)
		else $error("accepted segment with an endpoint outside");

endmodule

`default_nettype wire
